FILE: rtl/core/spcol_pkg.sv
// Shared types and constants for the sprite pixel collision block.
package spcol_pkg;

  localparam int SIDE_W   = 7;   // width of a side register
  localparam int POS_W    = 16;  // width of a sprite position
  localparam int EDGE_W   = 18;  // signed width of position plus side
  localparam int START_W  = 15;  // row offset times side plus column offset
  localparam int INDEX_W  = 12;  // width of a pixel index
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_TEST   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_OF_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_OF_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_OF_B     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_OF_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_A_PRESENT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_B_PRESENT = 3'd5;

  typedef struct packed {
    logic [1:0]              mode;
    logic [INDEX_W-1:0]      pixel_index;
    logic [7:0]              pixel_value;
    logic signed [POS_W-1:0] pos_ax;
    logic signed [POS_W-1:0] pos_ay;
    logic signed [POS_W-1:0] pos_bx;
    logic signed [POS_W-1:0] pos_by;
  } in_t;

  typedef struct packed {
    logic collision;
    logic boxes_overlap;
  } out_t;

  // Saturated sprite sides.
  typedef struct packed {
    logic [SIDE_W-1:0] wa;
    logic [SIDE_W-1:0] ha;
    logic [SIDE_W-1:0] wb;
    logic [SIDE_W-1:0] hb;
  } sides_t;

  // Overlap rectangle and scan start addresses.
  typedef struct packed {
    logic               box;
    logic [SIDE_W-1:0]  ow;
    logic [SIDE_W-1:0]  oh;
    logic [START_W-1:0] start_a;
    logic [START_W-1:0] start_b;
  } geom_t;

  function automatic logic signed [EDGE_W-1:0] pos_ext(input logic signed [POS_W-1:0] p);
    return EDGE_W'(p);
  endfunction

  function automatic logic signed [EDGE_W-1:0] side_ext(input logic [SIDE_W-1:0] s);
    return $signed({{(EDGE_W-SIDE_W){1'b0}}, s});
  endfunction

endpackage

FILE: rtl/core/spcol_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spcol_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/spcol_geom.sv
// Three-stage box test and overlap rectangle set-up for a collision test.
module spcol_geom (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  spcol_pkg::in_t      item,
  input  spcol_pkg::sides_t   sides,
  output logic                done,
  output spcol_pkg::geom_t    geom
);

  localparam int EW = spcol_pkg::EDGE_W;
  localparam int SW = spcol_pkg::SIDE_W;

  // stage 1: positions and far edges
  logic                 v1;
  logic signed [EW-1:0] ax, ay, bx, by, ea, fa, eb, fb;
  // stage 2: box result and overlap offsets
  logic                 v2;
  logic                 box2;
  logic [SW-1:0]        ow2, oh2, ca2, cb2, ra2, rb2;

  logic signed [EW-1:0] x1, y1, x2, y2;
  logic signed [EW-1:0] d_ow, d_oh, d_ca, d_cb, d_ra, d_rb;
  logic [2*SW-1:0]      prod_a, prod_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ax <= spcol_pkg::pos_ext(item.pos_ax);
    ay <= spcol_pkg::pos_ext(item.pos_ay);
    bx <= spcol_pkg::pos_ext(item.pos_bx);
    by <= spcol_pkg::pos_ext(item.pos_by);
    ea <= spcol_pkg::pos_ext(item.pos_ax) + spcol_pkg::side_ext(sides.wa);
    fa <= spcol_pkg::pos_ext(item.pos_ay) + spcol_pkg::side_ext(sides.ha);
    eb <= spcol_pkg::pos_ext(item.pos_bx) + spcol_pkg::side_ext(sides.wb);
    fb <= spcol_pkg::pos_ext(item.pos_by) + spcol_pkg::side_ext(sides.hb);
  end

  always_comb begin
    x1   = (ax > bx) ? ax : bx;
    y1   = (ay > by) ? ay : by;
    x2   = (ea < eb) ? ea : eb;
    y2   = (fa < fb) ? fa : fb;
    d_ow = x2 - x1;
    d_oh = y2 - y1;
    d_ca = x1 - ax;
    d_cb = x1 - bx;
    d_ra = y1 - ay;
    d_rb = y1 - by;
  end

  // Offsets are only meaningful when the boxes overlap; they then lie within a side.
  always_ff @(posedge clk) begin
    box2 <= !(ea <= bx || fa <= by || eb <= ax || fb <= ay);
    ow2  <= d_ow[SW-1:0];
    oh2  <= d_oh[SW-1:0];
    ca2  <= d_ca[SW-1:0];
    cb2  <= d_cb[SW-1:0];
    ra2  <= d_ra[SW-1:0];
    rb2  <= d_rb[SW-1:0];
  end

  always_comb begin
    prod_a = ra2 * sides.wa;
    prod_b = rb2 * sides.wb;
  end

  always_ff @(posedge clk) begin
    geom.box     <= box2;
    geom.ow      <= ow2;
    geom.oh      <= oh2;
    geom.start_a <= spcol_pkg::START_W'(prod_a) + spcol_pkg::START_W'(ca2);
    geom.start_b <= spcol_pkg::START_W'(prod_b) + spcol_pkg::START_W'(cb2);
  end

endmodule

FILE: rtl/core/spcol_scan.sv
// Overlap scan: walks the rectangle, reads both mask stores and looks for a shared pixel.
module spcol_scan #(
  parameter int AW = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  spcol_pkg::geom_t            geom,
  input  logic [spcol_pkg::SIDE_W-1:0] wa,
  input  logic [spcol_pkg::SIDE_W-1:0] wb,
  output logic [AW-1:0]               rd_addr_a,
  output logic [AW-1:0]               rd_addr_b,
  input  logic                        rd_data_a,
  input  logic                        rd_data_b,
  output logic                        done,
  output logic                        hit
);

  localparam int SW = spcol_pkg::SIDE_W;
  localparam int CW = (AW > spcol_pkg::START_W) ? AW : spcol_pkg::START_W;

  typedef enum logic [1:0] {
    SC_IDLE = 2'b01,
    SC_RUN  = 2'b10
  } scan_state_t;

  scan_state_t   state;
  logic [SW-1:0] col, row, ow_m1, oh_m1;
  logic [CW-1:0] addr_a, addr_b, base_a, base_b;
  logic          issuing, pend, pend_last;

  logic          last_now, row_end;
  logic [CW-1:0] wa_ext, wb_ext;

  assign wa_ext    = CW'(wa);
  assign wb_ext    = CW'(wb);
  assign row_end   = (col == ow_m1);
  assign last_now  = row_end && (row == oh_m1);
  assign rd_addr_a = addr_a[AW-1:0];
  assign rd_addr_b = addr_b[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SC_IDLE;
      done      <= 1'b0;
      issuing   <= 1'b0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        SC_IDLE: begin
          if (start) begin
            issuing   <= 1'b1;
            pend      <= 1'b0;
            pend_last <= 1'b0;
            state     <= SC_RUN;
          end
        end
        SC_RUN: begin
          pend      <= issuing;
          pend_last <= issuing && last_now;
          if (issuing && last_now) begin
            issuing <= 1'b0;
          end
          // Read data comes from the registered RAM read, in the cycle after its address.
          if (pend && rd_data_a && rd_data_b) begin
            issuing <= 1'b0;
            done    <= 1'b1;
            state   <= SC_IDLE;
          end else if (pend && pend_last) begin
            done  <= 1'b1;
            state <= SC_IDLE;
          end
        end
        default: begin
          state <= SC_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == SC_IDLE && start) begin
      col    <= '0;
      row    <= '0;
      ow_m1  <= geom.ow - SW'(1);
      oh_m1  <= geom.oh - SW'(1);
      addr_a <= CW'(geom.start_a);
      base_a <= CW'(geom.start_a);
      addr_b <= CW'(geom.start_b);
      base_b <= CW'(geom.start_b);
    end else if (state == SC_RUN && issuing && !last_now) begin
      if (row_end) begin
        // advance to the first column of the next row
        col    <= '0;
        row    <= row + SW'(1);
        base_a <= base_a + wa_ext;
        addr_a <= base_a + wa_ext;
        base_b <= base_b + wb_ext;
        addr_b <= base_b + wb_ext;
      end else begin
        col    <= col + SW'(1);
        addr_a <= addr_a + CW'(1);
        addr_b <= addr_b + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == SC_RUN && pend) begin
      if (rd_data_a && rd_data_b) begin
        hit <= 1'b1;
      end else if (pend_last) begin
        hit <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/sprite_pixel_collision.sv
// Sprite pixel collision: mask stores, configuration, test sequencing and result register.
// Loads (modes 0 and 1) give no result; one is accepted every cycle while no test is in progress.
// A test stalls the input through the geometry stages and, when both masks are present and
// the boxes meet, through a scan that reads overlap pixels from the mask read ports up to the first shared pixel.
// Its result is registered into the output, which holds it while the output is stalled.
// Reset: side registers to 8, presence bits to 0, no result pending; mask stores keep old data.
module sprite_pixel_collision #(
  parameter int MAX_SIDE = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  spcol_pkg::in_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output spcol_pkg::out_t                   out_data,
  input  logic                              cfg_write,
  input  logic [spcol_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spcol_pkg::SIDE_W-1:0]      cfg_data
);

  localparam int SW    = spcol_pkg::SIDE_W;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IXW   = (AW > spcol_pkg::INDEX_W) ? AW : spcol_pkg::INDEX_W;
  localparam logic [SW-1:0] SIDE_CAP = SW'((MAX_SIDE > 127) ? 127 : MAX_SIDE);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_GEOM   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } top_state_t;

  top_state_t        state;
  logic [SW-1:0]     width_of_a, height_of_a, width_of_b, height_of_b;
  logic              mask_a_present, mask_b_present;
  logic              res_hit, res_box;

  spcol_pkg::sides_t sides;
  spcol_pkg::geom_t  geom;
  logic              accept, test_start, geom_done, scan_start, scan_done, scan_hit;
  logic              both_present, scan_needed, idx_ok, out_load;
  logic              we_a, we_b, opaque;
  logic [IXW-1:0]    idx_wide;
  logic [AW-1:0]     waddr, rd_addr_a, rd_addr_b;
  logic              rd_data_a, rd_data_b;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign test_start = accept && (in_data.mode == spcol_pkg::MODE_TEST);

  assign sides.wa = (width_of_a  > SIDE_CAP) ? SIDE_CAP : width_of_a;
  assign sides.ha = (height_of_a > SIDE_CAP) ? SIDE_CAP : height_of_a;
  assign sides.wb = (width_of_b  > SIDE_CAP) ? SIDE_CAP : width_of_b;
  assign sides.hb = (height_of_b > SIDE_CAP) ? SIDE_CAP : height_of_b;

  // Drop loads whose index lies beyond the store.
  assign idx_ok   = (32'(in_data.pixel_index) < DEPTH);
  assign idx_wide = IXW'(in_data.pixel_index);
  assign waddr    = idx_wide[AW-1:0];
  assign opaque   = (in_data.pixel_value != 8'd0);
  assign we_a     = accept && idx_ok && (in_data.mode == spcol_pkg::MODE_LOAD_A);
  assign we_b     = accept && idx_ok && (in_data.mode == spcol_pkg::MODE_LOAD_B);

  assign both_present = mask_a_present && mask_b_present;
  assign scan_needed  = both_present && geom.box && (geom.ow != '0) && (geom.oh != '0);
  assign scan_start   = (state == ST_GEOM) && geom_done && scan_needed;
  assign out_load     = (state == ST_FINISH) && (!out_valid || !out_stall);

  spcol_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mask_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (opaque),
    .raddr (rd_addr_a),
    .rdata (rd_data_a)
  );

  spcol_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mask_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (opaque),
    .raddr (rd_addr_b),
    .rdata (rd_data_b)
  );

  spcol_geom u_geom (
    .clk   (clk),
    .rst   (rst),
    .start (test_start),
    .item  (in_data),
    .sides (sides),
    .done  (geom_done),
    .geom  (geom)
  );

  spcol_scan #(.AW(AW)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .geom      (geom),
    .wa        (sides.wa),
    .wb        (sides.wb),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .done      (scan_done),
    .hit       (scan_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_of_a     <= SW'(8);
      height_of_a    <= SW'(8);
      width_of_b     <= SW'(8);
      height_of_b    <= SW'(8);
      mask_a_present <= 1'b0;
      mask_b_present <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        spcol_pkg::REG_WIDTH_OF_A:     width_of_a     <= cfg_data;
        spcol_pkg::REG_HEIGHT_OF_A:    height_of_a    <= cfg_data;
        spcol_pkg::REG_WIDTH_OF_B:     width_of_b     <= cfg_data;
        spcol_pkg::REG_HEIGHT_OF_B:    height_of_b    <= cfg_data;
        spcol_pkg::REG_MASK_A_PRESENT: mask_a_present <= cfg_data[0];
        spcol_pkg::REG_MASK_B_PRESENT: mask_b_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (test_start) begin
            state <= ST_GEOM;
          end
        end
        ST_GEOM: begin
          if (geom_done) begin
            state <= scan_needed ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Without both masks the answer is the box test; an empty overlap never hits.
  always_ff @(posedge clk) begin
    if (state == ST_GEOM && geom_done) begin
      res_box <= geom.box;
      res_hit <= both_present ? 1'b0 : geom.box;
    end else if (state == ST_SCAN && scan_done) begin
      res_hit <= scan_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.collision     <= res_hit;
      out_data.boxes_overlap <= res_box;
    end
  end

endmodule
